@@ rtl/mau_pkg.sv @@
// Package for the modular arithmetic unit: opcodes, controller commands and
// register addresses. Used by the datapath, the controller and the top level of the unit.
package mau_pkg;

  localparam int ModW = 31;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;
  localparam logic [2:0] OP_INV = 3'd6;

  localparam logic [30:0] MODULUS_RESET = 31'd998244353;
  localparam logic [0:0] ADDR_MODULUS = 1'b0;

  // Datapath commands from the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,     // capture operands and modulus
    CMD_RED_STEP, // one bit of the shift-subtract reduction of a and b
    CMD_SETUP,    // choose base and exponent, acc = 1
    CMD_MUL_ACC,  // start acc * base reduction
    CMD_MUL_SQ,   // start base * base reduction
    CMD_MUL_AB,   // start a * b (multiply) or a * acc (divide) reduction
    CMD_PRED_STEP,// one bit of the product reduction
    CMD_PRED_DONE,// write reduced product back
    CMD_SHIFT,    // shift exponent right
    CMD_FINISH    // compute result into output register
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] dst; // 0 acc, 1 base, 2 multiply or divide product into acc
  } mau_ctl_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic red_last;
    logic pred_last;
    logic is_mul;
    logic is_exp_op;
    logic is_div;
    logic div_phase2;
    logic mod_small;
  } mau_sts_t;

endpackage

@@ rtl/mau_datapath.sv @@
// Datapath of the modular arithmetic unit: operand registers, one 31x31
// multiplier and bit-serial shift-subtract reducers. Depends on mau_pkg.
module mau_datapath
  import mau_pkg::*;
#(
  parameter int EXP_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mau_ctl_t             ctl_i,
  output mau_sts_t             sts_o,
  input  logic [ModW-1:0]      modulus_i,
  input  logic [2:0]           opcode_i,
  input  logic [31:0]          operand_a_i,
  input  logic [63:0]          operand_b_i,
  output logic [ModW-1:0]      result_o
);

  localparam int RedCntW = 7;
  // The exponent register also holds modulus minus two for inverse and divide.
  localparam int ExpQW = (EXP_WIDTH > ModW) ? EXP_WIDTH : ModW;

  logic [2:0]           op_q;
  logic [ModW-1:0]      m_q;
  logic [63:0]          raw_b_q;
  logic [63:0]          ra_q, rb_q;       // reduction shift registers
  logic [ModW:0]        rema_q, remb_q;   // partial remainders
  logic [RedCntW-1:0]   cnt_q;
  logic [ModW-1:0]      a_q, b_q, acc_q, base_q;
  logic [ExpQW-1:0]     exp_q;
  logic [61:0]          prod_q;
  logic [ModW:0]        prem_q;
  logic                 phase2_q;
  logic [1:0]           dst_q;

  // One restoring step: shift in a bit, subtract m if possible.
  function automatic logic [ModW:0] red_bit(logic [ModW:0] r, logic bin, logic [ModW-1:0] m);
    logic [ModW+1:0] t;
    t = {r, bin};
    if (t >= {2'b00, m}) t = t - {2'b00, m};
    return t[ModW:0];
  endfunction

  logic [61:0] mul_a, mul_b_w;
  logic [ModW-1:0] mx, my;
  always_comb begin
    mx = acc_q; my = base_q;
    unique case (ctl_i.cmd)
      CMD_MUL_SQ: begin mx = base_q; my = base_q; end
      CMD_MUL_AB: begin mx = a_q;    my = (op_q == OP_MUL) ? b_q : acc_q; end
      default:    begin mx = acc_q;  my = base_q; end
    endcase
    mul_a = {31'd0, mx} * {31'd0, my};
    mul_b_w = mul_a;
  end

  logic [ExpQW-1:0] mexp;
  always_comb begin
    mexp = ExpQW'(m_q - 31'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      phase2_q <= 1'b0;
    end else begin
      unique case (ctl_i.cmd)
        CMD_LOAD: begin
          cnt_q    <= '0;
          phase2_q <= 1'b0;
        end
        CMD_RED_STEP, CMD_PRED_STEP: cnt_q <= cnt_q + RedCntW'(1);
        CMD_MUL_ACC, CMD_MUL_SQ, CMD_MUL_AB: cnt_q <= '0;
        CMD_SETUP: if (op_q == OP_DIV && !phase2_q) phase2_q <= 1'b0;
        CMD_PRED_DONE: if (dst_q == 2'd2) phase2_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      CMD_LOAD: begin
        op_q    <= opcode_i;
        m_q     <= modulus_i;
        raw_b_q <= operand_b_i;
        ra_q    <= {operand_a_i, 32'd0};
        rb_q    <= operand_b_i;
        rema_q  <= '0;
        remb_q  <= '0;
      end
      CMD_RED_STEP: begin
        if (cnt_q < RedCntW'(32)) begin
          rema_q <= red_bit(rema_q, ra_q[63], m_q);
          ra_q   <= {ra_q[62:0], 1'b0};
        end
        remb_q <= red_bit(remb_q, rb_q[63], m_q);
        rb_q   <= {rb_q[62:0], 1'b0};
        a_q    <= rema_q[ModW-1:0];
        b_q    <= remb_q[ModW-1:0];
      end
      CMD_SETUP: begin
        acc_q <= 31'd1;
        if (op_q == OP_POW) begin
          base_q <= a_q;
          exp_q  <= ExpQW'(raw_b_q[EXP_WIDTH-1:0]);
        end else if (op_q == OP_INV) begin
          base_q <= a_q;
          exp_q  <= mexp;
        end else begin
          base_q <= b_q;
          exp_q  <= mexp;
        end
      end
      CMD_MUL_ACC, CMD_MUL_SQ, CMD_MUL_AB: begin
        prod_q <= mul_b_w;
        prem_q <= '0;
        dst_q  <= ctl_i.dst;
      end
      CMD_PRED_STEP: begin
        prem_q <= red_bit(prem_q, prod_q[61], m_q);
        prod_q <= {prod_q[60:0], 1'b0};
      end
      CMD_PRED_DONE: begin
        if (dst_q == 2'd1) base_q <= prem_q[ModW-1:0];
        else acc_q <= prem_q[ModW-1:0];
      end
      CMD_SHIFT: exp_q <= exp_q >> 1;
      CMD_FINISH: begin
        logic [ModW:0] s;
        logic [ModW:0] d;
        s = {1'b0, a_q} + {1'b0, b_q};
        d = {1'b0, a_q} - {1'b0, b_q};
        if (m_q < 31'd2) result_o <= '0;
        else begin
          unique case (op_q)
            OP_ADD: result_o <= (s >= {1'b0, m_q}) ? ModW'(s - {1'b0, m_q}) : s[ModW-1:0];
            OP_SUB: result_o <= (a_q >= b_q) ? d[ModW-1:0] : ModW'(d + {1'b0, m_q});
            OP_NEG: result_o <= (a_q == '0) ? '0 : m_q - a_q;
            OP_MUL, OP_DIV, OP_POW, OP_INV: result_o <= acc_q;
            default: result_o <= '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.exp_zero   = (exp_q == '0);
    sts_o.exp_lsb    = exp_q[0];
    sts_o.red_last   = (cnt_q == RedCntW'(64));
    // All 62 product bits are shifted in before the write-back.
    sts_o.pred_last  = (cnt_q == RedCntW'(62));
    sts_o.is_mul     = (op_q == OP_MUL);
    sts_o.is_exp_op  = (op_q == OP_POW) || (op_q == OP_INV) || (op_q == OP_DIV);
    sts_o.is_div     = (op_q == OP_DIV);
    sts_o.div_phase2 = phase2_q;
    sts_o.mod_small  = (m_q < 31'd2);
  end

endmodule

@@ rtl/mau_ctrl.sv @@
// Controller of the modular arithmetic unit: sequences reduction, the
// square-and-multiply loop and the output handshake. Depends on mau_pkg.
module mau_ctrl
  import mau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  mau_sts_t sts_i,
  output mau_ctl_t ctl_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_TEST  = 4'd3;
  localparam logic [3:0] S_MACC  = 4'd4;
  localparam logic [3:0] S_PRED  = 4'd5;
  localparam logic [3:0] S_MSQ   = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_MAB   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] next_q, next_d; // where to go after a product reduction
  logic       valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    next_d  = next_q;
    valid_d = valid_q;
    ctl_o.cmd = CMD_NONE;
    ctl_o.dst = 2'd0;
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        ctl_o.cmd = CMD_LOAD;
        state_d = S_RED;
      end
      S_RED: begin
        ctl_o.cmd = CMD_RED_STEP;
        if (sts_i.red_last) begin
          if (sts_i.mod_small) state_d = S_FIN;
          else if (sts_i.is_exp_op) state_d = S_SETUP;
          else if (sts_i.is_mul) state_d = S_MAB;
          else state_d = S_FIN;
        end
      end
      S_SETUP: begin ctl_o.cmd = CMD_SETUP; state_d = S_TEST; end
      S_TEST: begin
        if (sts_i.exp_zero) state_d = sts_i.is_div ? S_MAB : S_FIN;
        else if (sts_i.exp_lsb) state_d = S_MACC;
        else state_d = S_MSQ;
      end
      S_MACC: begin ctl_o.cmd = CMD_MUL_ACC; ctl_o.dst = 2'd0; next_d = 2'd0; state_d = S_PRED; end
      S_MSQ:  begin ctl_o.cmd = CMD_MUL_SQ; ctl_o.dst = 2'd1; next_d = 2'd1; state_d = S_PRED; end
      S_MAB: begin
        // Plain multiply forms a * b, divide forms a times the inverse in acc.
        ctl_o.cmd = CMD_MUL_AB; ctl_o.dst = 2'd2; next_d = 2'd2; state_d = S_PRED;
      end
      S_PRED: begin
        ctl_o.cmd = CMD_PRED_STEP;
        if (sts_i.pred_last) begin
          ctl_o.cmd = CMD_PRED_DONE;
          ctl_o.dst = next_q;
          unique case (next_q)
            2'd0:    state_d = S_MSQ;
            2'd1:    state_d = S_SHIFT;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SHIFT: begin ctl_o.cmd = CMD_SHIFT; state_d = S_TEST; end
      // The output register is overwritten only once the previous result has left.
      S_FIN: if (!valid_q || !out_stall_i) begin
        ctl_o.cmd = CMD_FINISH;
        state_d = S_OUT;
      end
      S_OUT: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      next_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = valid_q;

endmodule

@@ rtl/modular_arithmetic_unit.sv @@
// Modular arithmetic unit: add, subtract, negate, multiply, divide, power and
// inverse modulo a configurable modulus. Top level; depends on mau_pkg, mau_ctrl, mau_datapath.
//
// One request is worked on at a time; a finished result waits in the output
// register while the next request is already taken. Both operands are first
// reduced by a bit-serial shift-subtract loop. Every modular product uses the
// single 31x31 multiplier and then a 62-step serial reduction. Add, subtract and
// negate finish right after operand reduction; multiply adds one product. Power
// and inverse square the base once per exponent bit and multiply it into the
// accumulator for each set bit, over the exponent's length (up to EXP_WIDTH bits
// for power, 31 for inverse); divide adds one more product. A modulus below two
// gives zero right after operand reduction.
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int EXP_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        opcode_i,
  input  logic [31:0]       operand_a_i,
  input  logic [63:0]       operand_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ModW-1:0]   result_o
);

  logic [ModW-1:0] modulus_q;
  mau_ctl_t ctl;
  mau_sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) modulus_q <= MODULUS_RESET;
    else if (psel && penable && pwrite && paddr[2] == ADDR_MODULUS)
      modulus_q <= pwdata[ModW-1:0];
  end
  assign prdata = (paddr[2] == ADDR_MODULUS) ? {1'b0, modulus_q} : '0;

  mau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  mau_datapath #(.EXP_WIDTH(EXP_WIDTH)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .modulus_i(modulus_q),
    .opcode_i, .operand_a_i, .operand_b_i, .result_o
  );

endmodule

@@ rtl/mau_checker.sv @@
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Depends only on the top-level ports.
module mau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [30:0] result_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o)) else $error("result dropped");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second item taken");
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(result_o)) else $error("unknown result");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .result_o
);

@@ test/modular_arithmetic_unit_tb.sv @@
// Self-checking testbench for modular_arithmetic_unit: a directed table, then random
// requests over several moduli, all checked against an in-bench predictor.
// Depends on mau_pkg and the unit's RTL.
module modular_arithmetic_unit_tb
  import mau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_MODULUS = 0;
  localparam longint unsigned CYCLE_LIMIT = 100_000_000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [63:0] b;
    bit          known;
    logic [30:0] res;
  } req_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [63:0] operand_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ModW-1:0] result_o;

  logic [30:0] modulus_q = MODULUS_RESET;
  logic [30:0] result_q[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  longint unsigned cycle_cnt = 0;

  modular_arithmetic_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [30:0] modular_result(logic [2:0] op, logic [31:0] a_raw,
                                                 logic [63:0] b_raw, logic [30:0] modv);
    longint unsigned m, a, b, r;
    m = modv;
    if (m < 2) return '0;
    a = a_raw % m;
    b = b_raw % m;
    case (op)
      OP_ADD: begin
        r = a + b;
        if (r >= m) r -= m;
      end
      OP_SUB: r = (a >= b) ? a - b : a + m - b;
      OP_NEG: r = (a == 0) ? 0 : m - a;
      OP_MUL: r = (a * b) % m;
      OP_DIV: r = (a * pow_mod(b, m - 2, m)) % m;
      OP_POW: r = pow_mod(a, b_raw, m);
      OP_INV: r = pow_mod(a, m - 2, m);
      default: r = 0;
    endcase
    return r[30:0];
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("modular_arithmetic_unit_tb: done, errors");
      $finish;
    end
  end

  // Result side: random stall and comparison against the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected: result=%0d", result_o);
          err_cnt++;
        end else begin
          if (result_o !== result_q[0]) begin
            $error("field result: expected %0d, actual %0d", result_q[0], result_o);
            err_cnt++;
          end
          void'(result_q.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(int unsigned idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODULUS) modulus_q = val[30:0];
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Presents one request and returns at the edge where its transfer happens.
  task automatic send_req(logic [2:0] op, logic [31:0] a, logic [63:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    result_q.push_back(modular_result(op, a, b, modulus_q));
  endtask

  function automatic logic [31:0] pick_operand();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'(modulus_q) - 1;
      3: return 32'(modulus_q);
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(logic [30:0] modv, int unsigned count, inout int unsigned done_n);
    logic [2:0] op;
    logic [31:0] a;
    logic [63:0] b;
    int unsigned r;
    drain();
    write_reg(REG_MODULUS, {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0, modv});
    for (int unsigned i = 0; i < count; i++) begin
      if (done_n < 583) begin
        send_idle_pct = 23;
        recv_idle_pct = 63;
      end else if (done_n < 1166) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(0, 99);
      op = (r < 15) ? OP_ADD : (r < 30) ? OP_SUB : (r < 40) ? OP_NEG : (r < 62) ? OP_MUL :
           (r < 68) ? OP_DIV : (r < 90) ? OP_POW : (r < 96) ? OP_INV : OP_UNUSED;
      a = pick_operand();
      b = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) b = 64'(pick_operand());
      // Long exponents are costly, so most stay within eight bits.
      if (op == OP_POW && $urandom_range(0, 99) >= 3) b = 64'($urandom_range(0, 255));
      send_req(op, a, b);
      done_n++;
      if (done_n == 800) begin
        in_valid_i <= 1'b0;
        while (result_q.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    req_row_t rows[$];
    int unsigned done_n;
    rows = '{
      '{OP_ADD, 32'd0, 64'd0, 1'b1, 31'd0},
      '{OP_ADD, 32'd998244352, 64'd1, 1'b1, 31'd0},
      '{OP_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 31'd0},
      '{OP_SUB, 32'd0, 64'd1, 1'b1, 31'd998244352},
      '{OP_SUB, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 31'd0},
      '{OP_NEG, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 31'd0},
      '{OP_NEG, 32'd1, 64'd0, 1'b1, 31'd998244352},
      '{OP_NEG, 32'hFFFF_FFFF, 64'd5, 1'b0, 31'd0},
      '{OP_MUL, 32'd2, 64'd3, 1'b1, 31'd6},
      '{OP_MUL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 31'd0},
      '{OP_DIV, 32'd6, 64'd3, 1'b1, 31'd2},
      '{OP_DIV, 32'd7, 64'd0, 1'b0, 31'd0},
      '{OP_POW, 32'd2, 64'd10, 1'b1, 31'd1024},
      '{OP_POW, 32'd5, 64'd0, 1'b1, 31'd1},
      '{OP_POW, 32'd0, 64'd0, 1'b1, 31'd1},
      '{OP_POW, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 31'd0},
      '{OP_INV, 32'd0, 64'd0, 1'b1, 31'd0},
      '{OP_INV, 32'd1, 64'd0, 1'b1, 31'd1},
      '{OP_INV, 32'd998244352, 64'd0, 1'b1, 31'd998244352},
      '{OP_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 31'd0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_req(rows[i].op, rows[i].a, rows[i].b);
      // Typed-in values also guard the predictor itself.
      if (rows[i].known && result_q[$] !== rows[i].res) begin
        $error("field result: expected %0d, actual %0d (predictor, row %0d)",
               rows[i].res, result_q[$], i);
        err_cnt++;
      end
    end
    in_valid_i <= 1'b0;
    done_n = 0;
    random_phase(31'd2147483647, 400, done_n);
    random_phase(31'd2, 150, done_n);
    random_phase(31'd65521, 300, done_n);
    random_phase(31'd7, 200, done_n);
    random_phase(31'd1, 40, done_n);
    random_phase(31'd0, 20, done_n);
    random_phase(MODULUS_RESET, 640, done_n);
    drain();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("modular_arithmetic_unit_tb: done, clean");
    end else begin
      $display("modular_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mau_pkg.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
rtl/mau_checker.sv
test/modular_arithmetic_unit_tb.sv
